### rtl/core/mrc_pkg.sv
// shared types and constants for the mru key/value cache core
// no dependencies; imported by every module of the block
package mrc_pkg;

  localparam int NUM_ENTRIES = 16;
  localparam int SLOT_W      = $clog2(NUM_ENTRIES);
  localparam int CNT_W       = $clog2(NUM_ENTRIES + 1);
  localparam int KEY_W       = 32;
  localparam int VAL_W       = 32;
  localparam int CAP_W       = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  localparam logic ACT_GET = 1'b0;
  localparam logic ACT_PUT = 1'b1;

  localparam logic [VAL_W-1:0] MISS_VALUE = '1;
  localparam logic [VAL_W-1:0] PUT_VALUE  = '0;

  // controller to datapath commands
  typedef struct packed {
    logic capture;
    logic compare;
    logic commit;
  } mrc_cmd_t;

  // index of the lowest set bit, zero when none is set
  function automatic logic [SLOT_W-1:0] first_set(input logic [NUM_ENTRIES-1:0] v);
    logic [SLOT_W-1:0] idx;
    idx = '0;
    for (int i = NUM_ENTRIES - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = SLOT_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

### rtl/core/mrc_ctrl.sv
// sequencer for the mru key/value cache: capture, compare, commit
// depends on mrc_pkg for the command struct
module mrc_ctrl import mrc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  output mrc_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_COMMIT
  } state_e;

  state_e state_q;
  logic   busy_q;

  // state and busy flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      busy_q  <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (start) begin
            state_q <= ST_LOOKUP;
            busy_q  <= 1'b1;
          end
        end
        ST_LOOKUP: begin
          state_q <= ST_COMMIT;
        end
        ST_COMMIT: begin
          state_q <= ST_IDLE;
          busy_q  <= 1'b0;
        end
        default: begin
          state_q <= ST_IDLE;
          busy_q  <= 1'b0;
        end
      endcase
    end
  end

  // commands decoded from state
  always_comb begin
    cmd_o.capture = (state_q == ST_IDLE) && start;
    cmd_o.compare = (state_q == ST_LOOKUP);
    cmd_o.commit  = (state_q == ST_COMMIT);
  end

  assign busy = busy_q;

endmodule

### rtl/core/mrc_datapath.sv
// entry table, parallel key compare, mru slot tracking and result register
// depends on mrc_pkg for sizes, codes and the command struct
module mrc_datapath import mrc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mrc_cmd_t         cmd_i,
  input  logic             action_i,
  input  logic [KEY_W-1:0] lookup_key_i,
  input  logic [VAL_W-1:0] write_value_i,
  input  logic             cfg_we_i,
  input  logic [CAP_W-1:0] cfg_data_i,
  output logic             valid_o,
  output logic             hit_o,
  output logic [VAL_W-1:0] read_value_o
);

  // captured word
  logic             act_q;
  logic [KEY_W-1:0] key_q;
  logic [VAL_W-1:0] val_q;

  // entry store
  logic [KEY_W-1:0]       keys_q   [NUM_ENTRIES];
  logic [VAL_W-1:0]       values_q [NUM_ENTRIES];
  logic [NUM_ENTRIES-1:0] valid_q;
  logic [SLOT_W-1:0]      recent_q;
  logic [CNT_W-1:0]       occ_q;
  logic [CAP_W-1:0]       cap_q;

  // compare results
  logic              hit_q;
  logic [SLOT_W-1:0] slot_q;
  logic              free_ok_q;
  logic [SLOT_W-1:0] free_slot_q;
  logic              evict_q;

  // result register
  logic             res_valid_q;
  logic             res_hit_q;
  logic [VAL_W-1:0] res_value_q;

  logic [NUM_ENTRIES-1:0] match;
  logic [CNT_W-1:0]       eff_cap;
  logic                   put_new;
  logic                   do_write;
  logic [SLOT_W-1:0]      target;

  // match vector over all entries
  always_comb begin
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      match[i] = valid_q[i] && (keys_q[i] == key_q);
    end
  end

  // capacity clamped to one .. table size
  always_comb begin
    if (cap_q == '0) begin
      eff_cap = CNT_W'(1);
    end else if (CNT_W'(cap_q) > CNT_W'(NUM_ENTRIES)) begin
      eff_cap = CNT_W'(NUM_ENTRIES);
    end else begin
      eff_cap = CNT_W'(cap_q);
    end
  end

  // slot written by a put: the matching slot, else the mru slot on eviction, else the first free slot
  always_comb begin
    put_new  = cmd_i.commit && (act_q == ACT_PUT) && !hit_q;
    do_write = 1'b0;
    target   = free_slot_q;
    if (cmd_i.commit && (act_q == ACT_PUT)) begin
      if (hit_q) begin
        target   = slot_q;
        do_write = 1'b1;
      end else if (evict_q) begin
        target   = recent_q;
        do_write = 1'b1;
      end else if (free_ok_q) begin
        target   = free_slot_q;
        do_write = 1'b1;
      end
    end
  end

  // capture and compare registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      act_q <= action_i;
      key_q <= lookup_key_i;
      val_q <= write_value_i;
    end
    if (cmd_i.compare) begin
      hit_q       <= |match;
      slot_q      <= first_set(match);
      free_ok_q   <= |(~valid_q);
      free_slot_q <= first_set(~valid_q);
      evict_q     <= (occ_q >= eff_cap) && (occ_q != '0) && valid_q[recent_q];
    end
  end

  // key and value table, written on commit
  always_ff @(posedge clk_i) begin
    if (do_write) begin
      values_q[target] <= val_q;
      if (put_new) begin
        keys_q[target] <= key_q;
      end
    end
  end

  // valid bits, mru slot, occupancy and capacity
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      recent_q <= '0;
      occ_q    <= '0;
      cap_q    <= CAP_RESET;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_data_i;
      end
      if (do_write) begin
        valid_q[target] <= 1'b1;
        recent_q        <= target;
        if (put_new && !evict_q) begin
          occ_q <= occ_q + CNT_W'(1);
        end
      end else if (cmd_i.commit && hit_q) begin
        recent_q <= slot_q;
      end
    end
  end

  // result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= cmd_i.commit;
    end
  end

  // result word
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      res_hit_q <= hit_q;
      if (act_q == ACT_PUT) begin
        res_value_q <= PUT_VALUE;
      end else if (hit_q) begin
        res_value_q <= values_q[slot_q];
      end else begin
        res_value_q <= MISS_VALUE;
      end
    end
  end

  assign valid_o      = res_valid_q;
  assign hit_o        = res_hit_q;
  assign read_value_o = res_value_q;

endmodule

### rtl/core/mru_replacement_key_value_cache_core.sv
// Fully associative 16-entry key/value cache with most-recently-used eviction.
//
// Command channel: a word (action, lookup_key, write_value) is taken at a rising
// edge with start high and busy low. action 0 is a get, 1 is a put.
// Result channel: valid_o is high for exactly one cycle with hit_o and
// read_value_o; the receiver cannot stall and must take the word then.
// Config channel: cfg_valid_i/cfg_ready_o write capacity_limit (5 bits);
// cfg_ready_o is always high. Write it only while the block is idle.
//
// Sequencing: a word runs through capture, compare and commit, and no new word
// is taken until commit is done: compare does the parallel key compare and slot
// search, commit the table update and result register.
// Reset: the store comes up empty (valid bits and occupancy cleared), the
// mru slot is zero and capacity_limit is 16. No clearing pass is needed.
// Depends on mrc_pkg, mrc_ctrl and mrc_datapath.
module mru_replacement_key_value_cache_core import mrc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  logic             action_i,
  input  logic [KEY_W-1:0] lookup_key_i,
  input  logic [VAL_W-1:0] write_value_i,
  output logic             valid_o,
  output logic             hit_o,
  output logic [VAL_W-1:0] read_value_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [CAP_W-1:0] cfg_data_i
);

  mrc_cmd_t cmd;

  // config channel never stalls
  assign cfg_ready_o = 1'b1;

  // sequencer
  mrc_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .cmd_o  (cmd)
  );

  // table and result path
  mrc_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .action_i      (action_i),
    .lookup_key_i  (lookup_key_i),
    .write_value_i (write_value_i),
    .cfg_we_i      (cfg_valid_i && cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .valid_o       (valid_o),
    .hit_o         (hit_o),
    .read_value_o  (read_value_o)
  );

endmodule

### tb/mru_replacement_key_value_cache_core_tb.sv
// self-checking testbench for the mru key/value cache core
// depends on mrc_pkg and mru_replacement_key_value_cache_core
module mru_replacement_key_value_cache_core_tb;
  import mrc_pkg::*;

  localparam int HALF_PERIOD  = 6;
  localparam int RESET_CYCLES = 3;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 8;
  localparam int POOL_N       = 20;
  localparam int PHASE_N      = 8;
  localparam int PHASE_WORDS  = 250;
  localparam int DIR_N        = 20;

  // how a directed row is checked
  localparam logic CHK_TYPED = 1'b1;
  localparam logic CHK_MODEL = 1'b0;

  typedef struct packed {
    logic             hit;
    logic [VAL_W-1:0] value;
  } lookup_result_t;

  typedef struct packed {
    logic             act;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
    logic             chk;
    logic             exp_hit;
    logic [VAL_W-1:0] exp_value;
  } cmd_row_t;

  logic             clk_i;
  logic             rst_ni;
  logic             start;
  logic             busy;
  logic             action_i;
  logic [KEY_W-1:0] lookup_key_i;
  logic [VAL_W-1:0] write_value_i;
  logic             valid_o;
  logic             hit_o;
  logic [VAL_W-1:0] read_value_o;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic [CAP_W-1:0] cfg_data_i;

  // shadow copy of the cache contents
  logic [KEY_W-1:0] shadow_keys   [NUM_ENTRIES];
  logic [VAL_W-1:0] shadow_values [NUM_ENTRIES];
  logic             shadow_valid  [NUM_ENTRIES];
  int               shadow_recent;
  int               shadow_count;
  logic [CAP_W-1:0] shadow_capacity;

  lookup_result_t   pending_results[$];
  int               mismatch_count;
  int               cycle_count;
  int               sender_idle_pct;
  logic [KEY_W-1:0] key_pool [POOL_N];

  // directed words: empty store, extremes, update, hit returning all ones
  cmd_row_t directed_rows [DIR_N] = '{
    '{ACT_GET, 32'h0000_0000, 32'h0000_0000, CHK_TYPED, 1'b0, MISS_VALUE},
    '{ACT_GET, 32'h8000_0000, 32'h0000_0000, CHK_TYPED, 1'b0, MISS_VALUE},
    '{ACT_PUT, 32'h7fff_ffff, 32'h8000_0000, CHK_TYPED, 1'b0, PUT_VALUE},
    '{ACT_GET, 32'h7fff_ffff, 32'h0000_0000, CHK_TYPED, 1'b1, 32'h8000_0000},
    '{ACT_PUT, 32'h8000_0000, 32'h7fff_ffff, CHK_TYPED, 1'b0, PUT_VALUE},
    '{ACT_PUT, 32'hffff_ffff, 32'hffff_ffff, CHK_TYPED, 1'b0, PUT_VALUE},
    '{ACT_PUT, 32'h0000_0000, 32'h0000_0000, CHK_TYPED, 1'b0, PUT_VALUE},
    '{ACT_GET, 32'h0000_0000, 32'hffff_ffff, CHK_TYPED, 1'b1, 32'h0000_0000},
    '{ACT_PUT, 32'h7fff_ffff, 32'h1234_5678, CHK_TYPED, 1'b1, PUT_VALUE},
    '{ACT_GET, 32'h7fff_ffff, 32'h0000_0000, CHK_TYPED, 1'b1, 32'h1234_5678},
    '{ACT_GET, 32'hffff_ffff, 32'h0000_0000, CHK_TYPED, 1'b1, 32'hffff_ffff},
    '{ACT_GET, 32'hffff_fffe, 32'h0000_0000, CHK_TYPED, 1'b0, MISS_VALUE},
    '{ACT_GET, 32'h8000_0000, 32'h0000_0000, CHK_TYPED, 1'b1, 32'h7fff_ffff},
    '{ACT_PUT, 32'h5555_5555, 32'haaaa_aaaa, CHK_TYPED, 1'b0, PUT_VALUE},
    '{ACT_GET, 32'haaaa_aaaa, 32'h0000_0000, CHK_TYPED, 1'b0, MISS_VALUE},
    '{ACT_PUT, 32'haaaa_aaaa, 32'h5555_5555, CHK_MODEL, 1'b0, PUT_VALUE},
    '{ACT_GET, 32'h5555_5555, 32'h0000_0000, CHK_MODEL, 1'b0, PUT_VALUE},
    '{ACT_GET, 32'haaaa_aaaa, 32'h0000_0000, CHK_MODEL, 1'b0, PUT_VALUE},
    '{ACT_PUT, 32'h0000_0001, 32'h8000_0001, CHK_MODEL, 1'b0, PUT_VALUE},
    '{ACT_GET, 32'h0000_0001, 32'h0000_0000, CHK_MODEL, 1'b0, PUT_VALUE}
  };

  // capacity used in each random phase
  logic [CAP_W-1:0] phase_capacity [PHASE_N] = '{
    5'd0, 5'd9, 5'd12, 5'd31, 5'd17, 5'd16, 5'd5, 5'd1
  };

  mru_replacement_key_value_cache_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .action_i      (action_i),
    .lookup_key_i  (lookup_key_i),
    .write_value_i (write_value_i),
    .valid_o       (valid_o),
    .hit_o         (hit_o),
    .read_value_o  (read_value_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  // clock
  always #HALF_PERIOD clk_i = ~clk_i;

  // one cache access against the shadow copy, returns the expected word
  function automatic lookup_result_t cache_access(input logic act,
                                                  input logic [KEY_W-1:0] key,
                                                  input logic [VAL_W-1:0] value);
    lookup_result_t res;
    int match;
    int target;
    int limit;
    match = -1;
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      if (match < 0 && shadow_valid[i] && shadow_keys[i] == key) begin
        match = i;
      end
    end
    if (act == ACT_GET) begin
      if (match >= 0) begin
        shadow_recent = match;
        res.hit   = 1'b1;
        res.value = shadow_values[match];
      end else begin
        res.hit   = 1'b0;
        res.value = MISS_VALUE;
      end
    end else if (match >= 0) begin
      // update in place
      shadow_values[match] = value;
      shadow_recent = match;
      res.hit   = 1'b1;
      res.value = PUT_VALUE;
    end else begin
      res.hit   = 1'b0;
      res.value = PUT_VALUE;
      // zero acts as one, anything above the table acts as the table size
      limit = int'(shadow_capacity);
      if (limit == 0) begin
        limit = 1;
      end
      if (limit > NUM_ENTRIES) begin
        limit = NUM_ENTRIES;
      end
      target = -1;
      if (shadow_count >= limit && shadow_count > 0 && shadow_valid[shadow_recent]) begin
        // evict the most recent entry and reuse its slot
        target = shadow_recent;
      end else begin
        for (int i = NUM_ENTRIES - 1; i >= 0; i--) begin
          if (!shadow_valid[i]) begin
            target = i;
          end
        end
        if (target >= 0) begin
          shadow_count++;
        end
      end
      if (target >= 0) begin
        shadow_keys[target]   = key;
        shadow_values[target] = value;
        shadow_valid[target]  = 1'b1;
        shadow_recent = target;
      end
    end
    return res;
  endfunction

  // send one command word; entered and left just after a falling edge
  task automatic send_word(input cmd_row_t row);
    lookup_result_t res;
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start         <= 1'b1;
    action_i      <= row.act;
    lookup_key_i  <= row.key;
    write_value_i <= row.value;
    @(posedge clk_i);
    while (busy) begin
      @(posedge clk_i);
    end
    res = cache_access(row.act, row.key, row.value);
    if (row.chk == CHK_TYPED) begin
      res.hit   = row.exp_hit;
      res.value = row.exp_value;
    end
    pending_results.push_back(res);
    @(negedge clk_i);
  endtask

  // wait for every result, then write the capacity register
  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    while (pending_results.size() != 0 || busy) begin
      @(negedge clk_i);
    end
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= cap;
    @(posedge clk_i);
    while (!cfg_ready_o) begin
      @(posedge clk_i);
    end
    shadow_capacity = cap;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // result checker
  always @(posedge clk_i) begin
    lookup_result_t want;
    if (rst_ni && valid_o) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result word hit=%0b value=%h", $time, hit_o,
                 read_value_o);
        mismatch_count++;
      end else begin
        want = pending_results[0];
        pending_results.delete(0);
        if (hit_o !== want.hit) begin
          $display("%0t: hit mismatch, expected %0b, actual %0b", $time, want.hit,
                   hit_o);
          mismatch_count++;
        end
        if (read_value_o !== want.value) begin
          $display("%0t: read_value mismatch, expected %h, actual %h", $time,
                   want.value, read_value_o);
          mismatch_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // stimulus
  initial begin
    cmd_row_t row;
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    start         = 1'b0;
    action_i      = ACT_GET;
    lookup_key_i  = '0;
    write_value_i = '0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    mismatch_count  = 0;
    cycle_count     = 0;
    sender_idle_pct = 38;
    shadow_capacity = CAP_RESET;
    shadow_recent   = 0;
    shadow_count    = 0;
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      shadow_valid[i]  = 1'b0;
      shadow_keys[i]   = '0;
      shadow_values[i] = '0;
    end
    // extremes stay in the key pool, up to four of the rest are refreshed per phase
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'h0000_0001;
    key_pool[2] = 32'hffff_ffff;
    key_pool[3] = 32'h8000_0000;
    key_pool[4] = 32'h7fff_ffff;
    for (int i = 5; i < POOL_N; i++) begin
      key_pool[i] = $urandom;
    end

    // reset
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed words at the reset capacity
    for (int i = 0; i < DIR_N; i++) begin
      send_word(directed_rows[i]);
    end
    start <= 1'b0;

    // random phases, each at its own capacity
    for (int p = 0; p < PHASE_N; p++) begin
      write_capacity(phase_capacity[p]);
      sender_idle_pct = (p < 3) ? 38 : (p < 6) ? 45 : 0;
      for (int i = 0; i < 4; i++) begin
        key_pool[$urandom_range(POOL_N - 1, 5)] = $urandom;
      end
      for (int i = 0; i < PHASE_WORDS; i++) begin
        row.act       = $urandom_range(1) ? ACT_PUT : ACT_GET;
        row.key       = ($urandom_range(99) < 85) ? key_pool[$urandom_range(POOL_N - 1)]
                                                  : $urandom;
        row.value     = $urandom;
        row.chk       = CHK_MODEL;
        row.exp_hit   = 1'b0;
        row.exp_value = PUT_VALUE;
        send_word(row);
      end
      start <= 1'b0;
    end

    // drain and report
    while (pending_results.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
